>>> src/ubrt_pkg.sv
// Shared types, constants and helpers for the UDP burst receive tracker.
// No dependencies; imported by the tracker top level.
`default_nettype none

package ubrt_pkg;

	// Default sizing of the tracker.
	localparam int unsigned SLOT_COUNT_DEF = 256;
	localparam int unsigned MAX_BURST_DEF  = 64;

	// Header field values.
	localparam logic [31:0] HEADER_BYTES = 32'd20;
	localparam logic [31:0] TYPE_DATA    = 32'd3;
	localparam logic [31:0] TYPE_REQUEST = 32'd4;
	localparam logic [7:0]  TIMEOUT_RST  = 8'd3;

	// Reply kinds.
	localparam logic [1:0] KIND_ERROR    = 2'd0;
	localparam logic [1:0] KIND_RESPONSE = 2'd1;
	localparam logic [1:0] KIND_DATA     = 2'd2;

	// One tracking slot as stored in the slot memory.
	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] sequence_no;
		logic [31:0] received;
		logic [31:0] burst;
		logic [31:0] length;
		logic [31:0] last_seen;
	} slot_entry_t;

	localparam int unsigned ENTRY_W = $bits(slot_entry_t);

	// Reduce an address byte modulo the slot count by restoring subtraction.
	// The count is at least 16, so the quotient fits in four bits.
	function automatic logic [7:0] slot_of(input logic [7:0] v, input int unsigned n);
		logic [11:0] r;
		logic [11:0] d;
		r = {4'b0, v};
		for (int k = 3; k >= 0; k--) begin
			d = 12'(n << k);
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[7:0];
	endfunction

endpackage

`default_nettype wire

>>> src/ubrt_item_if.sv
// Input channel of the burst tracker: valid/ready handshake with the parsed
// header or age check fields. No dependencies.
`default_nettype none

interface ubrt_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] src_addr;
	logic [15:0] src_port;
	logic [31:0] packet_type;
	logic [31:0] burst_count;
	logic [31:0] packet_length;
	logic [31:0] sequence_req;
	logic [31:0] now_seconds;
	logic [7:0]  check_slot;

	modport source (
		output valid, command, src_addr, src_port, packet_type, burst_count,
		       packet_length, sequence_req, now_seconds, check_slot,
		input  ready
	);
	modport sink (
		input  valid, command, src_addr, src_port, packet_type, burst_count,
		       packet_length, sequence_req, now_seconds, check_slot,
		output ready
	);
endinterface

`default_nettype wire

>>> src/ubrt_reply_if.sv
// Output channel of the burst tracker: valid/ready handshake with the reply
// header fields. No dependencies.
`default_nettype none

interface ubrt_reply_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reply_kind;
	logic [31:0] dest_addr;
	logic [15:0] dest_port;
	logic [31:0] reply_burst;
	logic [31:0] reply_number;
	logic [31:0] reply_length;
	logic [31:0] reply_sequence;
	logic        last_of_run;

	modport source (
		output valid, reply_kind, dest_addr, dest_port, reply_burst, reply_number,
		       reply_length, reply_sequence, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, reply_kind, dest_addr, dest_port, reply_burst, reply_number,
		       reply_length, reply_sequence, last_of_run,
		output ready
	);
endinterface

`default_nettype wire

>>> src/ubrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ubrt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/udp_burst_receive_tracker_unit.sv
// Top level of the UDP burst receive tracker: sequencer, slot valid bits and
// reply register. Depends on ubrt_pkg, ubrt_item_if, ubrt_reply_if, ubrt_ram.
//
//  channel | direction | handshake   | contents
//  --------+-----------+-------------+-------------------------------------------
//  item    | in        | valid/ready | header fields or age check of one slot
//  reply   | out       | valid/ready | error, burst response or data header
//  cfg     | in        | cfg_we      | timeout_seconds, write when idle, unchecked
//
// A data packet, a malformed header or an age check of a slot in range goes on to
// the evaluate step. The transfer of a data packet or age check issues the slot
// memory read; the evaluate step writes the slot back for a counted packet that
// does not end its burst. A request emits up to MAX_BURST data headers in the
// burst step; one that emits none and an age check out of range end at transfer.
// Slot valid bits are flip-flops cleared by reset, so no clearing pass is run.
// A full reply register that is not drained stalls the evaluate and burst steps.
`default_nettype none

module udp_burst_receive_tracker_unit
	import ubrt_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int unsigned MAX_BURST  = MAX_BURST_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	ubrt_item_if.sink      item,
	ubrt_reply_if.source   reply,
	input  wire            cfg_we,
	input  wire [7:0]      cfg_data
);

	localparam int unsigned SW = $clog2(SLOT_COUNT);
	localparam int unsigned RW = $clog2(MAX_BURST + 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_BURST = 2'd2;

	// Operation held for the evaluate step.
	localparam logic [1:0] OP_AGE  = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_BAD  = 2'd2;

	logic [1:0]            state_q;
	logic [1:0]            op_q;
	logic [7:0]            timeout_q;
	logic [SLOT_COUNT-1:0] used_q;

	logic [31:0]   addr_q;
	logic [15:0]   port_q;
	logic [31:0]   burst_q;
	logic [31:0]   len_q;
	logic [31:0]   seq_q;
	logic [31:0]   now_q;
	logic [SW-1:0] slot_q;
	logic [RW-1:0] run_q;
	logic [RW-1:0] idx_q;

	logic        out_valid_q;
	logic [1:0]  o_kind_q;
	logic [31:0] o_addr_q;
	logic [15:0] o_port_q;
	logic [31:0] o_burst_q;
	logic [31:0] o_number_q;
	logic [31:0] o_length_q;
	logic [31:0] o_seq_q;
	logic        o_last_q;

	// Input decode.
	logic          accept;
	logic          is_data;
	logic          is_req;
	logic          age_ok;
	logic          req_ok;
	logic [SW-1:0] data_slot;
	logic [SW-1:0] rd_slot;
	logic [RW-1:0] run_d;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign is_data    = !item.command && (item.packet_type == TYPE_DATA);
	assign is_req     = !item.command && (item.packet_type == TYPE_REQUEST);
	assign age_ok     = item.command && ({1'b0, item.check_slot} < 9'(SLOT_COUNT));
	assign req_ok     = (item.packet_length >= HEADER_BYTES) && (item.burst_count != 32'd0);
	assign data_slot  = SW'(slot_of(item.src_addr[7:0], SLOT_COUNT));
	assign rd_slot    = item.command ? item.check_slot[SW-1:0] : data_slot;
	assign run_d      = (item.burst_count < 32'(MAX_BURST)) ? RW'(item.burst_count)
	                                                        : RW'(MAX_BURST);

	// Slot memory.
	slot_entry_t rd_entry;
	slot_entry_t wr_entry;
	logic        ram_we;
	logic [ENTRY_W-1:0] rd_bits;

	ubrt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (wr_entry),
		.re    (accept && (age_ok || is_data)),
		.raddr (rd_slot),
		.rdata (rd_bits)
	);

	assign rd_entry = slot_entry_t'(rd_bits);

	// Evaluate the slot and pick the reply.
	logic        out_free;
	logic        slot_used;
	logic        match;
	logic [31:0] idle_time;
	logic        expire;
	logic        done;
	logic        emit;
	logic        set_used;
	logic        clr_used;
	logic [1:0]  e_kind;
	logic [31:0] e_addr;
	logic [15:0] e_port;
	logic [31:0] e_burst;
	logic [31:0] e_number;
	logic [31:0] e_length;
	logic [31:0] e_seq;
	logic        e_last;

	assign out_free  = !out_valid_q || reply.ready;
	assign slot_used = used_q[slot_q];
	assign match     = (rd_entry.addr == addr_q) && (rd_entry.port == port_q) &&
	                   (rd_entry.sequence_no == seq_q);
	assign idle_time = now_q - rd_entry.last_seen;
	assign expire    = slot_used && (now_q >= rd_entry.last_seen) &&
	                   (idle_time > {24'b0, timeout_q});

	// Merge the packet into the slot: count on a match, open a free slot.
	always_comb begin
		wr_entry = rd_entry;
		if (slot_used) begin
			wr_entry.received = rd_entry.received + 32'd1;
		end else begin
			wr_entry.addr        = addr_q;
			wr_entry.port        = port_q;
			wr_entry.sequence_no = seq_q;
			wr_entry.received    = 32'd1;
			wr_entry.burst       = burst_q;
			wr_entry.length      = len_q;
		end
		wr_entry.last_seen = now_q;
	end

	assign done = (wr_entry.received == wr_entry.burst);

	always_comb begin
		emit     = 1'b0;
		ram_we   = 1'b0;
		set_used = 1'b0;
		clr_used = 1'b0;
		e_kind   = KIND_RESPONSE;
		e_addr   = rd_entry.addr;
		e_port   = rd_entry.port;
		e_burst  = rd_entry.burst;
		e_number = rd_entry.received;
		e_length = rd_entry.length;
		e_seq    = rd_entry.sequence_no;
		e_last   = 1'b1;
		if (state_q == ST_EVAL && out_free) begin
			unique case (op_q)
				OP_AGE: begin
					emit     = expire;
					clr_used = expire;
				end
				OP_DATA: begin
					if (slot_used && !match) begin
						emit   = 1'b1;
						e_kind = KIND_ERROR;
					end else if (done) begin
						emit     = 1'b1;
						clr_used = 1'b1;
						e_addr   = wr_entry.addr;
						e_port   = wr_entry.port;
						e_burst  = wr_entry.burst;
						e_number = wr_entry.received;
						e_length = wr_entry.length;
						e_seq    = wr_entry.sequence_no;
					end else begin
						ram_we   = 1'b1;
						set_used = 1'b1;
					end
				end
				OP_BAD: begin
					emit     = 1'b1;
					e_kind   = KIND_ERROR;
					e_addr   = addr_q;
					e_port   = port_q;
					e_burst  = 32'd0;
					e_number = 32'd0;
					e_length = HEADER_BYTES;
					e_seq    = 32'd0;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end else if (state_q == ST_BURST && out_free) begin
			emit     = 1'b1;
			e_kind   = KIND_DATA;
			e_addr   = addr_q;
			e_port   = port_q;
			e_burst  = burst_q;
			e_number = 32'(idx_q);
			e_length = len_q;
			e_seq    = 32'd0;
			e_last   = (RW'(idx_q + 1'b1) == run_q);
		end
	end

	// Sequencer and slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_AGE;
			used_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (set_used) begin
				used_q[slot_q] <= 1'b1;
			end else if (clr_used) begin
				used_q[slot_q] <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						priority if (item.command) begin
							op_q    <= OP_AGE;
							state_q <= age_ok ? ST_EVAL : ST_IDLE;
						end else if (is_data) begin
							op_q    <= OP_DATA;
							state_q <= ST_EVAL;
						end else if (is_req) begin
							state_q <= req_ok ? ST_BURST : ST_IDLE;
						end else begin
							op_q    <= OP_BAD;
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BURST: begin
					if (emit) begin
						idx_q <= RW'(idx_q + 1'b1);
						if (e_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= item.src_addr;
			port_q  <= item.src_port;
			burst_q <= item.burst_count;
			len_q   <= item.packet_length;
			seq_q   <= item.sequence_req;
			now_q   <= item.now_seconds;
			slot_q  <= rd_slot;
			run_q   <= run_d;
		end
	end

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	// Reply register: load on emit, drop after the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_kind_q   <= e_kind;
			o_addr_q   <= e_addr;
			o_port_q   <= e_port;
			o_burst_q  <= e_burst;
			o_number_q <= e_number;
			o_length_q <= e_length;
			o_seq_q    <= e_seq;
			o_last_q   <= e_last;
		end
	end

	assign reply.valid          = out_valid_q;
	assign reply.reply_kind     = o_kind_q;
	assign reply.dest_addr      = o_addr_q;
	assign reply.dest_port      = o_port_q;
	assign reply.reply_burst    = o_burst_q;
	assign reply.reply_number   = o_number_q;
	assign reply.reply_length   = o_length_q;
	assign reply.reply_sequence = o_seq_q;
	assign reply.last_of_run    = o_last_q;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for udp_burst_receive_tracker_unit: headers and age checks go in
// through a paced driver, replies are predicted by a slot-table tracker and checked in order.
// Depends on ubrt_pkg, ubrt_item_if, ubrt_reply_if and the tracker RTL.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ubrt_pkg::*;

	localparam logic CMD_HEADER    = 1'b0;
	localparam logic CMD_AGE       = 1'b1;
	localparam int   FLOWS         = 8;
	localparam int   LONG_HOLD     = 300;
	localparam int   SETTLE_CYCLES = 80;
	localparam int   MAX_REPORTS   = 10;
	localparam int   RUN_LIMIT_NS  = 5_000_000;

	typedef enum logic [1:0] {PACE_OPEN, PACE_LIGHT, PACE_HEAVY, PACE_BEAT} pace_t;

	typedef struct packed {
		logic        command;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [31:0] packet_type;
		logic [31:0] burst_count;
		logic [31:0] packet_length;
		logic [31:0] sequence_req;
		logic [31:0] now_seconds;
		logic [7:0]  check_slot;
	} burst_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] burst;
		logic [31:0] number;
		logic [31:0] length;
		logic [31:0] sequence_no;
		logic        last_of_run;
	} reply_hdr_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [7:0]  cfg_data    = 8'd0;
	burst_item_t offer       = '0;
	logic        offer_valid = 1'b0;
	logic        offer_taken = 1'b0;
	logic        reply_ready = 1'b0;

	// Items waiting for the driver, replies waiting for the DUT
	burst_item_t pending_items[$];
	reply_hdr_t  replies_due[$];
	int          fail_count = 0;

	// Tracker copy: timeout register and slot table
	logic [7:0]  trk_timeout = TIMEOUT_RST;
	logic        trk_used  [SLOT_COUNT_DEF];
	logic [31:0] trk_addr  [SLOT_COUNT_DEF];
	logic [15:0] trk_port  [SLOT_COUNT_DEF];
	logic [31:0] trk_seq   [SLOT_COUNT_DEF];
	logic [31:0] trk_count [SLOT_COUNT_DEF];
	logic [31:0] trk_burst [SLOT_COUNT_DEF];
	logic [31:0] trk_len   [SLOT_COUNT_DEF];
	logic [31:0] trk_seen  [SLOT_COUNT_DEF];
	reply_hdr_t  staged;
	logic        staged_ok = 1'b0;

	// Stimulus state: live sender flows and the wall clock in seconds
	logic [31:0] flow_addr  [FLOWS];
	logic [15:0] flow_port  [FLOWS];
	logic [31:0] flow_seq   [FLOWS];
	logic [31:0] flow_burst [FLOWS];
	logic [31:0] flow_len   [FLOWS];
	int          flow_sent  [FLOWS];
	logic [31:0] sec_now     = 32'd0;
	logic [7:0]  cur_timeout = TIMEOUT_RST;

	// Pacing state of the driver and of the reply side
	int    burst_left    = 0;
	int    gap_left      = 0;
	int    pace_count    = 0;
	pace_t pace_mode     = PACE_OPEN;
	logic  long_hold_req = 1'b0;
	int    hold_count    = 0;

	ubrt_item_if  item_ch ();
	ubrt_reply_if reply_ch ();

	assign item_ch.valid         = offer_valid;
	assign item_ch.command       = offer.command;
	assign item_ch.src_addr      = offer.src_addr;
	assign item_ch.src_port      = offer.src_port;
	assign item_ch.packet_type   = offer.packet_type;
	assign item_ch.burst_count   = offer.burst_count;
	assign item_ch.packet_length = offer.packet_length;
	assign item_ch.sequence_req  = offer.sequence_req;
	assign item_ch.now_seconds   = offer.now_seconds;
	assign item_ch.check_slot    = offer.check_slot;
	assign reply_ch.ready        = reply_ready;

	udp_burst_receive_tracker_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.reply    (reply_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

	// ---------------------------------------------------------------- tracker

	task automatic drop_slot(input int unsigned s);
		trk_used[s]  = 1'b0;
		trk_addr[s]  = '0;
		trk_port[s]  = '0;
		trk_seq[s]   = '0;
		trk_count[s] = '0;
		trk_burst[s] = '0;
		trk_len[s]   = '0;
		trk_seen[s]  = '0;
	endtask

	function automatic reply_hdr_t slot_reply(input logic [1:0] kind, input int unsigned s);
		reply_hdr_t r;
		r = '{kind, trk_addr[s], trk_port[s], trk_burst[s], trk_count[s], trk_len[s],
			trk_seq[s], 1'b0};
		return r;
	endfunction

	// Hold back the newest reply so the final one of a run can be flagged
	task automatic stage(input reply_hdr_t r);
		if (staged_ok) replies_due.push_back(staged);
		staged    = r;
		staged_ok = 1'b1;
	endtask

	task automatic track_item(input burst_item_t it);
		int unsigned s;
		int unsigned run;
		int unsigned n;
		reply_hdr_t  r;
		staged_ok = 1'b0;
		if (it.command == CMD_AGE) begin
			// expire an idle slot; time running backwards never expires
			s = it.check_slot;
			if (s < SLOT_COUNT_DEF && trk_used[s] && it.now_seconds >= trk_seen[s] &&
			    it.now_seconds - trk_seen[s] > {24'd0, trk_timeout}) begin
				stage(slot_reply(KIND_RESPONSE, s));
				drop_slot(s);
			end
		end else if (it.packet_type != TYPE_DATA && it.packet_type != TYPE_REQUEST) begin
			r = '{KIND_ERROR, it.src_addr, it.src_port, 32'd0, 32'd0, HEADER_BYTES, 32'd0, 1'b0};
			stage(r);
		end else if (it.packet_type == TYPE_REQUEST) begin
			// emit the requested data headers, clamped to the burst limit
			if (it.packet_length >= HEADER_BYTES) begin
				run = (it.burst_count < MAX_BURST_DEF) ? it.burst_count : MAX_BURST_DEF;
				for (n = 0; n < run; n++) begin
					r = '{KIND_DATA, it.src_addr, it.src_port, it.burst_count, 32'(n),
						it.packet_length, 32'd0, 1'b0};
					stage(r);
				end
			end
		end else begin
			s = it.src_addr[7:0] % SLOT_COUNT_DEF;
			if (trk_used[s] && (trk_addr[s] != it.src_addr || trk_port[s] != it.src_port ||
			    trk_seq[s] != it.sequence_req)) begin
				// slot held by someone else: tell the owner, leave the slot alone
				stage(slot_reply(KIND_ERROR, s));
			end else begin
				if (trk_used[s]) begin
					trk_count[s] = trk_count[s] + 32'd1;
				end else begin
					trk_used[s]  = 1'b1;
					trk_addr[s]  = it.src_addr;
					trk_port[s]  = it.src_port;
					trk_burst[s] = it.burst_count;
					trk_len[s]   = it.packet_length;
					trk_count[s] = 32'd1;
					trk_seq[s]   = it.sequence_req;
				end
				trk_seen[s] = it.now_seconds;
				if (trk_count[s] == trk_burst[s]) begin
					stage(slot_reply(KIND_RESPONSE, s));
					drop_slot(s);
				end
			end
		end
		if (staged_ok) begin
			staged.last_of_run = 1'b1;
			replies_due.push_back(staged);
		end
	endtask

	// ---------------------------------------------------------------- checking

	function automatic string hdr_text(input reply_hdr_t r);
		return $sformatf("kind %0d addr %h port %h burst %h number %h length %h seq %h last %b",
			r.kind, r.addr, r.port, r.burst, r.number, r.length, r.sequence_no, r.last_of_run);
	endfunction

	task automatic log_failure(input string what);
		if (fail_count < MAX_REPORTS) $display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_reply();
		reply_hdr_t got;
		reply_hdr_t want;
		got = '{reply_ch.reply_kind, reply_ch.dest_addr, reply_ch.dest_port, reply_ch.reply_burst,
			reply_ch.reply_number, reply_ch.reply_length, reply_ch.reply_sequence,
			reply_ch.last_of_run};
		if (replies_due.size() == 0) begin
			log_failure({"reply with nothing outstanding: ", hdr_text(got)});
		end else begin
			want = replies_due.pop_front();
			if (got.kind !== want.kind || got.addr !== want.addr || got.port !== want.port ||
			    got.burst !== want.burst || got.number !== want.number ||
			    got.length !== want.length || got.sequence_no !== want.sequence_no ||
			    got.last_of_run !== want.last_of_run) begin
				log_failure({"reply mismatch\n  expected ", hdr_text(want),
					"\n  actual   ", hdr_text(got)});
			end
		end
	endtask

	// Sample transfers, register writes and replies at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) trk_timeout = cfg_data;
			if (reply_ch.valid && reply_ch.ready) check_reply();
			if (item_ch.valid && item_ch.ready) track_item(offer);
			offer_taken <= item_ch.valid && item_ch.ready;
		end
	end

	// ---------------------------------------------------------------- driving

	// Offer pending items in bursts with random gaps; hold an item until its transfer
	always @(negedge clk) begin
		if (arst_n && (!offer_valid || offer_taken)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				offer_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				offer <= pending_items.pop_front();
				offer_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1, 2: gap_left = $urandom_range(1, 4);
						default: gap_left = $urandom_range(5, 30);
					endcase
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				offer_valid <= 1'b0;
			end
		end
	end

	// Reply side: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (long_hold_req && hold_count < LONG_HOLD) begin
			hold_count = hold_count + 1;
			reply_ready <= 1'b0;
		end else begin
			if (!long_hold_req) hold_count = 0;
			pace_count = pace_count + 1;
			if (pace_count % 48 == 0) pace_mode = pace_t'($urandom_range(0, 3));
			case (pace_mode)
				PACE_OPEN:  reply_ready <= 1'b1;
				PACE_LIGHT: reply_ready <= ($urandom_range(0, 3) != 0);
				PACE_HEAVY: reply_ready <= ($urandom_range(0, 3) == 0);
				default:    reply_ready <= ((pace_count % 8) < 4);
			endcase
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic burst_item_t noise_item();
		burst_item_t it;
		it.command       = 1'($urandom_range(0, 1));
		it.src_addr      = $urandom();
		it.src_port      = 16'($urandom());
		it.packet_type   = $urandom();
		it.burst_count   = $urandom();
		it.packet_length = $urandom();
		it.sequence_req  = $urandom();
		it.now_seconds   = $urandom();
		it.check_slot    = 8'($urandom());
		return it;
	endfunction

	function automatic burst_item_t header_item(input logic [31:0] addr, input logic [15:0] port,
			input logic [31:0] ptype, input logic [31:0] burst, input logic [31:0] len,
			input logic [31:0] seq, input logic [31:0] now);
		burst_item_t it;
		it               = noise_item();
		it.command       = CMD_HEADER;
		it.src_addr      = addr;
		it.src_port      = port;
		it.packet_type   = ptype;
		it.burst_count   = burst;
		it.packet_length = len;
		it.sequence_req  = seq;
		it.now_seconds   = now;
		return it;
	endfunction

	function automatic burst_item_t age_item(input logic [7:0] slot, input logic [31:0] now);
		burst_item_t it;
		it             = noise_item();
		it.command     = CMD_AGE;
		it.check_slot  = slot;
		it.now_seconds = now;
		return it;
	endfunction

	task automatic new_flow(input int k);
		flow_addr[k] = $urandom();
		if ($urandom_range(0, 1)) flow_addr[k][7:0] = 8'($urandom_range(0, 31));
		flow_port[k]  = 16'($urandom());
		flow_seq[k]   = $urandom();
		flow_burst[k] = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
		flow_len[k]   = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(20, 1500));
		flow_sent[k]  = 0;
	endtask

	// Wait until every item is in and every reply is out, then let the block go quiet
	task automatic settle();
		while (pending_items.size() != 0 || offer_valid || replies_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(negedge clk);
		cfg_we   <= 1'b0;
		cur_timeout = v;
	endtask

	// Mostly in-order flow packets, with age checks, requests, junk and stray data mixed in
	task automatic random_phase(input int count);
		int          k;
		int          pick;
		burst_item_t it;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			k    = $urandom_range(0, FLOWS - 1);
			if ($urandom_range(0, 19) == 0) sec_now = $urandom();
			else sec_now = sec_now + $urandom_range(0, 2);
			if (pick < 55) begin
				it = header_item(flow_addr[k], flow_port[k], TYPE_DATA, flow_burst[k],
					flow_len[k], flow_seq[k], sec_now);
				if ($urandom_range(0, 9) == 0) begin
					// spoil the sequence or port so the slot owner gets an error
					if ($urandom_range(0, 1)) it.sequence_req[$urandom_range(0, 31)] ^= 1'b1;
					else it.src_port[$urandom_range(0, 15)] ^= 1'b1;
				end else begin
					flow_sent[k]++;
					if (flow_sent[k] >= ((flow_burst[k] == 0) ? 3 : int'(flow_burst[k])))
						new_flow(k);
				end
			end else if (pick < 67) begin
				it = age_item(flow_addr[k][7:0], sec_now + $urandom_range(0, 2 * cur_timeout + 4));
			end else if (pick < 74) begin
				it = age_item(8'($urandom()), $urandom());
			end else if (pick < 86) begin
				it = header_item($urandom(), 16'($urandom()), TYPE_REQUEST,
					($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 8)),
					($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 19)) :
					($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(20, 1500)),
					$urandom(), sec_now);
			end else if (pick < 93) begin
				it = noise_item();
				it.command = CMD_HEADER;
				if ($urandom_range(0, 1)) it.packet_type = $urandom_range(0, 7);
			end else begin
				it = noise_item();
				it.command     = CMD_HEADER;
				it.packet_type = TYPE_DATA;
				it.burst_count = $urandom_range(0, 4);
				it.now_seconds = sec_now;
			end
			pending_items.push_back(it);
		end
	endtask

	initial begin
		for (int s = 0; s < SLOT_COUNT_DEF; s++) drop_slot(s);
		for (int k = 0; k < FLOWS; k++) new_flow(k);
		sec_now = $urandom_range(0, 1000);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// malformed types at the field extremes
		pending_items.push_back(header_item(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(header_item(32'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
			32'd0));
		// requests: too short, empty burst, single header, clamped burst
		pending_items.push_back(header_item(32'h0A00_0005, 16'd7000, TYPE_REQUEST, 32'd5,
			HEADER_BYTES - 32'd1, 32'd0, 32'd50));
		pending_items.push_back(header_item(32'h0A00_0005, 16'd7000, TYPE_REQUEST, 32'd0,
			HEADER_BYTES, 32'd0, 32'd50));
		pending_items.push_back(header_item(32'h0A00_0005, 16'd7000, TYPE_REQUEST, 32'd1,
			HEADER_BYTES, 32'd0, 32'd50));
		pending_items.push_back(header_item(32'h0A00_0006, 16'd7001, TYPE_REQUEST, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd9, 32'd51));
		// a burst of two completes, a burst of one completes at once
		pending_items.push_back(header_item(32'h0A00_0001, 16'd5000, TYPE_DATA, 32'd2, 32'd1400,
			32'd7, 32'd100));
		pending_items.push_back(header_item(32'h0A00_0001, 16'd5000, TYPE_DATA, 32'd2, 32'd1400,
			32'd7, 32'd101));
		pending_items.push_back(header_item(32'h0A00_0002, 16'd5000, TYPE_DATA, 32'd1, 32'd1400,
			32'd7, 32'd102));
		// open a slot, then hit it with another address, a wrong sequence and a wrong port
		pending_items.push_back(header_item(32'hC0A8_0010, 16'd9, TYPE_DATA, 32'd3, 32'd512,
			32'd1, 32'd10));
		pending_items.push_back(header_item(32'h0B00_0010, 16'd9, TYPE_DATA, 32'd3, 32'd512,
			32'd1, 32'd11));
		pending_items.push_back(header_item(32'hC0A8_0010, 16'd9, TYPE_DATA, 32'd3, 32'd512,
			32'd2, 32'd11));
		pending_items.push_back(header_item(32'hC0A8_0010, 16'd10, TYPE_DATA, 32'd3, 32'd512,
			32'd1, 32'd11));
		// age checks: too young, time gone backwards, expired, then free
		pending_items.push_back(age_item(8'h10, 32'd12));
		pending_items.push_back(age_item(8'h10, 32'd9));
		pending_items.push_back(age_item(8'h10, 32'd14));
		pending_items.push_back(age_item(8'h10, 32'd100));
		// a zero burst never completes and waits for expiry near the top of time
		pending_items.push_back(header_item(32'h0000_00FF, 16'd0, TYPE_DATA, 32'd0, HEADER_BYTES,
			32'hFFFF_FFFF, 32'hFFFF_FFF0));
		pending_items.push_back(header_item(32'h0000_00FF, 16'd0, TYPE_DATA, 32'd0, HEADER_BYTES,
			32'hFFFF_FFFF, 32'hFFFF_FFF2));
		pending_items.push_back(age_item(8'hFF, 32'hFFFF_FFFF));
		pending_items.push_back(age_item(8'h00, 32'd0));
		settle();

		// zero timeout: equal time holds, one second later expires
		write_timeout(8'd0);
		pending_items.push_back(header_item(32'h1234_5620, 16'd1, TYPE_DATA, 32'd5, 32'd64,
			32'd3, 32'd500));
		pending_items.push_back(age_item(8'h20, 32'd500));
		pending_items.push_back(age_item(8'h20, 32'd501));
		settle();

		// largest timeout on both sides of the edge
		write_timeout(8'd255);
		pending_items.push_back(header_item(32'h8765_4330, 16'd2, TYPE_DATA, 32'd9, 32'd100,
			32'd4, 32'd1000));
		pending_items.push_back(age_item(8'h30, 32'd1255));
		pending_items.push_back(age_item(8'h30, 32'd1256));
		settle();

		write_timeout(8'($urandom_range(1, 12)));
		random_phase(30);
		settle();

		// hold the reply side off while long requests keep arriving
		long_hold_req = 1'b1;
		repeat (6) begin
			pending_items.push_back(header_item($urandom(), 16'($urandom()), TYPE_REQUEST,
				32'($urandom_range(64, 67)), 32'($urandom_range(20, 1500)), $urandom(), sec_now));
		end
		random_phase(12);
		wait (hold_count == LONG_HOLD);
		long_hold_req = 1'b0;
		settle();

		write_timeout(8'd0);
		random_phase(30);
		settle();

		write_timeout(8'd255);
		random_phase(30);
		settle();

		write_timeout(8'($urandom_range(1, 8)));
		random_phase(30);
		settle();

		if (fail_count == 0 && replies_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> files.f
src/ubrt_pkg.sv
src/ubrt_item_if.sv
src/ubrt_reply_if.sv
src/ubrt_ram.sv
src/udp_burst_receive_tracker_unit.sv
verif/tb_top.sv
